// File: src/mrb_pkg.sv
`timescale 1ns / 1ps

package mrb_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int HIST_W     = 32;
    localparam int INDEX_W    = 6;
    localparam int MAX_MODES  = 64;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 29;
    localparam int COEF_SET_W = 3 * COEF_W;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd268435456);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_P1,
        S_P2,
        S_P3,
        S_ACC,
        S_WB,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_PREV1,
        OP_PREV2,
        OP_DRIVE
    } op_sel_t;

    typedef struct packed {
        logic    sample_ld;
        logic    rd_en;
        op_sel_t op_sel;
        logic    mul_en;
        logic    acc_load;
        logic    acc_add;
        logic    acc_round;
        logic    hist_we;
        logic    out_load;
    } dp_ctrl_t;

endpackage

// File: src/mrb_in_if.sv
`timescale 1ns / 1ps

interface mrb_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [mrb_pkg::SAMPLE_W-1:0]  sample;
    logic        [mrb_pkg::INDEX_W-1:0]   mode_index;
    logic signed [mrb_pkg::COEF_W-1:0]    coef_prev1;
    logic signed [mrb_pkg::COEF_W-1:0]    coef_prev2;
    logic signed [mrb_pkg::COEF_W-1:0]    coef_drive;

    modport source (
        output valid, mode, sample, mode_index, coef_prev1, coef_prev2, coef_drive,
        input  ready
    );

    modport sink (
        input  valid, mode, sample, mode_index, coef_prev1, coef_prev2, coef_drive,
        output ready
    );
endinterface

// File: src/mrb_out_if.sv
`timescale 1ns / 1ps

interface mrb_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mrb_pkg::HIST_W-1:0]  out_sample;

    modport source (
        output valid, out_sample,
        input  ready
    );

    modport sink (
        input  valid, out_sample,
        output ready
    );
endinterface

// File: src/mrb_ctrl.sv
`timescale 1ns / 1ps

module mrb_ctrl #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_mode,
    input  logic                out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output logic [IDX_W-1:0]    addr,
    output mrb_pkg::dp_ctrl_t   dp
);

    mrb_pkg::state_t  state_reg;
    mrb_pkg::state_t  state_next;
    logic [IDX_W-1:0] mode_cnt_reg;
    logic [IDX_W-1:0] mode_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             last_mode;
    logic             sample_accept;
    logic             out_free;

    assign last_mode     = (mode_cnt_reg == IDX_W'(DEPTH - 1));
    assign sample_accept = in_valid && !in_mode && (state_reg == mrb_pkg::S_IDLE);
    assign out_free      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrb_pkg::S_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next = mrb_pkg::S_FETCH;
                end
            end
            mrb_pkg::S_FETCH: state_next = mrb_pkg::S_P1;
            mrb_pkg::S_P1:    state_next = mrb_pkg::S_P2;
            mrb_pkg::S_P2:    state_next = mrb_pkg::S_P3;
            mrb_pkg::S_P3:    state_next = mrb_pkg::S_ACC;
            mrb_pkg::S_ACC:   state_next = mrb_pkg::S_WB;
            mrb_pkg::S_WB:
            begin
                state_next = last_mode ? mrb_pkg::S_DONE : mrb_pkg::S_FETCH;
            end
            mrb_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = mrb_pkg::S_IDLE;
                end
            end
            default: state_next = mrb_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        dp            = '0;
        dp.op_sel     = mrb_pkg::OP_PREV1;
        in_ready      = 1'b0;
        mode_cnt_next = mode_cnt_reg;
        case (state_reg)
            mrb_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (sample_accept)
                begin
                    dp.sample_ld  = 1'b1;
                    mode_cnt_next = '0;
                end
            end
            mrb_pkg::S_FETCH:
            begin
                dp.rd_en = 1'b1;
            end
            mrb_pkg::S_P1:
            begin
                dp.mul_en = 1'b1;
                dp.op_sel = mrb_pkg::OP_PREV1;
            end
            mrb_pkg::S_P2:
            begin
                dp.mul_en   = 1'b1;
                dp.op_sel   = mrb_pkg::OP_PREV2;
                dp.acc_load = 1'b1;
            end
            mrb_pkg::S_P3:
            begin
                dp.mul_en  = 1'b1;
                dp.op_sel  = mrb_pkg::OP_DRIVE;
                dp.acc_add = 1'b1;
            end
            mrb_pkg::S_ACC:
            begin
                dp.acc_add   = 1'b1;
                dp.acc_round = 1'b1;
            end
            mrb_pkg::S_WB:
            begin
                dp.hist_we = 1'b1;
                if (!last_mode)
                begin
                    mode_cnt_next = mode_cnt_reg + 1'b1;
                end
            end
            mrb_pkg::S_DONE:
            begin
                dp.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (dp.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrb_pkg::S_IDLE;
            mode_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_cnt_reg  <= mode_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign addr      = mode_cnt_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: src/mrb_mem.sv
`timescale 1ns / 1ps

module mrb_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  coef_we,
    input  logic [IDX_W-1:0]                      coef_waddr,
    input  logic [mrb_pkg::COEF_SET_W-1:0]        coef_wdata,
    input  logic [IDX_W-1:0]                      addr,
    input  mrb_pkg::dp_ctrl_t                     dp,
    input  logic signed [mrb_pkg::HIST_W-1:0]     new_val,
    output logic signed [mrb_pkg::COEF_W-1:0]     c1,
    output logic signed [mrb_pkg::COEF_W-1:0]     c2,
    output logic signed [mrb_pkg::COEF_W-1:0]     c3,
    output logic signed [mrb_pkg::HIST_W-1:0]     h1,
    output logic signed [mrb_pkg::HIST_W-1:0]     h2
);

    logic [mrb_pkg::COEF_SET_W-1:0] coef_mem [DEPTH];
    logic [2*mrb_pkg::HIST_W-1:0]   hist_mem [DEPTH];

    logic [DEPTH-1:0]               coef_valid_reg;
    logic [DEPTH-1:0]               coef_valid_next;
    logic [DEPTH-1:0]               hist_valid_reg;
    logic [DEPTH-1:0]               hist_valid_next;
    logic [mrb_pkg::COEF_SET_W-1:0] coef_rd_reg;
    logic [2*mrb_pkg::HIST_W-1:0]   hist_rd_reg;
    logic                           coef_rd_ok_reg;
    logic                           coef_rd_ok_next;
    logic                           hist_rd_ok_reg;
    logic                           hist_rd_ok_next;
    logic [mrb_pkg::COEF_SET_W-1:0] coef_rd;
    logic [2*mrb_pkg::HIST_W-1:0]   hist_rd;

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (dp.rd_en)
        begin
            coef_rd_reg <= coef_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp.hist_we)
        begin
            hist_mem[addr] <= {h1, new_val};
        end
        if (dp.rd_en)
        begin
            hist_rd_reg <= hist_mem[addr];
        end
    end

    always_comb
    begin
        coef_valid_next = coef_valid_reg;
        hist_valid_next = hist_valid_reg;
        coef_rd_ok_next = coef_rd_ok_reg;
        hist_rd_ok_next = hist_rd_ok_reg;
        if (coef_we)
        begin
            coef_valid_next[coef_waddr] = 1'b1;
        end
        if (dp.hist_we)
        begin
            hist_valid_next[addr] = 1'b1;
        end
        if (dp.rd_en)
        begin
            coef_rd_ok_next = coef_valid_reg[addr];
            hist_rd_ok_next = hist_valid_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg <= '0;
            hist_valid_reg <= '0;
            coef_rd_ok_reg <= 1'b0;
            hist_rd_ok_reg <= 1'b0;
        end
        else
        begin
            coef_valid_reg <= coef_valid_next;
            hist_valid_reg <= hist_valid_next;
            coef_rd_ok_reg <= coef_rd_ok_next;
            hist_rd_ok_reg <= hist_rd_ok_next;
        end
    end

    assign coef_rd = coef_rd_ok_reg ? coef_rd_reg : '0;
    assign hist_rd = hist_rd_ok_reg ? hist_rd_reg : '0;

    assign c1 = coef_rd[mrb_pkg::COEF_W-1:0];
    assign c2 = coef_rd[2*mrb_pkg::COEF_W-1:mrb_pkg::COEF_W];
    assign c3 = coef_rd[3*mrb_pkg::COEF_W-1:2*mrb_pkg::COEF_W];
    assign h1 = hist_rd[mrb_pkg::HIST_W-1:0];
    assign h2 = hist_rd[2*mrb_pkg::HIST_W-1:mrb_pkg::HIST_W];

endmodule

// File: src/mrb_mac.sv
`timescale 1ns / 1ps

module mrb_mac #(
    parameter int TOT_W = 39
) (
    input  logic                                  clk,
    input  mrb_pkg::dp_ctrl_t                     dp,
    input  logic signed [mrb_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [mrb_pkg::COEF_W-1:0]     c1,
    input  logic signed [mrb_pkg::COEF_W-1:0]     c2,
    input  logic signed [mrb_pkg::COEF_W-1:0]     c3,
    input  logic signed [mrb_pkg::HIST_W-1:0]     h1,
    input  logic signed [mrb_pkg::HIST_W-1:0]     h2,
    output logic signed [mrb_pkg::HIST_W-1:0]     new_val,
    output logic signed [mrb_pkg::HIST_W-1:0]     out_sample
);

    localparam int ACC_W = mrb_pkg::ACC_W;
    localparam int TOP_B = mrb_pkg::FRAC_SHIFT + mrb_pkg::HIST_W - 1;

    logic signed [mrb_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [mrb_pkg::COEF_W-1:0]   op_a;
    logic signed [mrb_pkg::COEF_W-1:0]   op_b;
    logic signed [mrb_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mrb_pkg::PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [ACC_W-1:0]             acc_next;
    logic signed [TOT_W-1:0]             total_reg;
    logic signed [TOT_W-1:0]             total_next;
    logic signed [mrb_pkg::HIST_W-1:0]   out_sample_reg;
    logic signed [mrb_pkg::HIST_W-1:0]   out_sat;
    logic                                acc_fits;
    logic                                total_fits;

    always_comb
    begin
        case (dp.op_sel)
            mrb_pkg::OP_PREV1:
            begin
                op_a = c1;
                op_b = h1;
            end
            mrb_pkg::OP_PREV2:
            begin
                op_a = c2;
                op_b = h2;
            end
            mrb_pkg::OP_DRIVE:
            begin
                op_a = c3;
                op_b = mrb_pkg::COEF_W'(sample_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (dp.acc_load)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else if (dp.acc_add)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg)
                     + (dp.acc_round ? mrb_pkg::HALF_LSB : ACC_W'(0));
        end
    end

    // The rounded value is acc_reg shifted down by FRAC_SHIFT, or saturated.
    assign acc_fits = (&acc_reg[ACC_W-1:TOP_B]) || !(|acc_reg[ACC_W-1:TOP_B]);

    always_comb
    begin
        if (acc_fits)
        begin
            new_val = acc_reg[TOP_B:mrb_pkg::FRAC_SHIFT];
        end
        else
        begin
            new_val = acc_reg[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    assign total_fits = (&total_reg[TOT_W-1:mrb_pkg::HIST_W-1])
                     || !(|total_reg[TOT_W-1:mrb_pkg::HIST_W-1]);

    always_comb
    begin
        if (total_fits)
        begin
            out_sat = total_reg[mrb_pkg::HIST_W-1:0];
        end
        else
        begin
            out_sat = total_reg[TOT_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (dp.sample_ld)
        begin
            total_next = '0;
        end
        else if (dp.hist_we)
        begin
            total_next = total_reg + TOT_W'(new_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp.sample_ld)
        begin
            sample_reg <= sample;
        end
        if (dp.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (dp.out_load)
        begin
            out_sample_reg <= out_sat;
        end
        acc_reg   <= acc_next;
        total_reg <= total_next;
    end

    assign out_sample = out_sample_reg;

endmodule

// File: src/modal_resonator_bank.sv
`timescale 1ns / 1ps

// A bank of two-pole resonators driven by one audio sample. Each sample item
// runs all modes in turn through a single 32 by 32 bit multiplier. Each mode
// has one memory read, three products and their accumulation, rounding and
// write-back of the history. A sample item occupies the block for a pass over
// M modes, where M is NUM_MODES capped at 64, and the input is not ready during
// that time. Modes from M upwards cannot be given coefficients, stay silent and
// are not visited. A coefficient item is taken while the block is idle and
// yields no result. After reset all coefficients and histories read as zero at
// once, with no clearing pass. The result sits in an output register, so a new
// item may be accepted while it waits for transfer. If that earlier result has
// still not been taken when the next pass ends, the block holds in its final
// state, with the input not ready, until it is.

module modal_resonator_bank #(
    parameter int NUM_MODES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    mrb_in_if.sink           item,
    mrb_out_if.source        result
);

    localparam int DEPTH = (NUM_MODES < mrb_pkg::MAX_MODES) ? NUM_MODES : mrb_pkg::MAX_MODES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W = mrb_pkg::HIST_W + IDX_W + 1;

    mrb_pkg::dp_ctrl_t                   dp;
    logic [IDX_W-1:0]                    addr;
    logic                                coef_we;
    logic signed [mrb_pkg::COEF_W-1:0]   c1;
    logic signed [mrb_pkg::COEF_W-1:0]   c2;
    logic signed [mrb_pkg::COEF_W-1:0]   c3;
    logic signed [mrb_pkg::HIST_W-1:0]   h1;
    logic signed [mrb_pkg::HIST_W-1:0]   h2;
    logic signed [mrb_pkg::HIST_W-1:0]   new_val;

    assign coef_we = item.valid && item.ready && item.mode
                  && ({1'b0, item.mode_index} < (mrb_pkg::INDEX_W + 1)'(DEPTH));

    mrb_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_mode   (item.mode),
        .out_ready (result.ready),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .addr      (addr),
        .dp        (dp)
    );

    mrb_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_we    (coef_we),
        .coef_waddr (item.mode_index[IDX_W-1:0]),
        .coef_wdata ({item.coef_drive, item.coef_prev2, item.coef_prev1}),
        .addr       (addr),
        .dp         (dp),
        .new_val    (new_val),
        .c1         (c1),
        .c2         (c2),
        .c3         (c3),
        .h1         (h1),
        .h2         (h2)
    );

    mrb_mac #(
        .TOT_W (TOT_W)
    ) u_mac (
        .clk        (clk),
        .dp         (dp),
        .sample     (item.sample),
        .c1         (c1),
        .c2         (c2),
        .c3         (c3),
        .h1         (h1),
        .h2         (h2),
        .new_val    (new_val),
        .out_sample (result.out_sample)
    );

    // A sample transfer starts a pass over the modes, so the input is busy next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && !item.mode) |=> !item.ready)
        else $error("input still ready after a sample transfer");

    // A coefficient transfer is finished in its own cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.mode) |=> item.ready)
        else $error("input not ready after a coefficient transfer");

    // A result only appears at the end of a pass, while the input is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(!item.ready))
        else $error("result raised while the block was idle");

endmodule
